// ----- sv/vnoise_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package vnoise_pkg;

	localparam int ADDR_W = 3;

	localparam logic REG_IDX_SEED = 1'b0;

	localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
	localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
	localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

	localparam int HASH_SHIFT_A = 13;
	localparam int HASH_SHIFT_B = 16;

	localparam logic [17:0] THREE_Q16 = 18'd196608;

	typedef logic [3:0][15:0] corner4_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

endpackage
`default_nettype wire

// ----- sv/vnoise_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vnoise_cfg
	import vnoise_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output logic      [31:0]       seed
);

	logic [31:0] seed_q;
	logic        wr_seed;

	assign pready  = 1'b1;
	assign wr_seed = psel && penable && pwrite && (paddr[2] == REG_IDX_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (wr_seed) begin
			seed_q <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_IDX_SEED) begin
			prdata = seed_q;
		end
	end

	assign seed = seed_q;

endmodule
`default_nettype wire

// ----- sv/vnoise_hash.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vnoise_hash
	import vnoise_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire stage_en_t   en,
	input  wire logic [31:0] coord_x_s1,
	input  wire logic [31:0] coord_y_s1,
	input  wire logic [31:0] seed,
	output corner4_t         corner_s4
);

	localparam logic [31:0] OFS_X  = HASH_MUL_X;
	localparam logic [31:0] OFS_Y  = HASH_MUL_Y;
	localparam logic [31:0] OFS_XY = 32'(HASH_MUL_X + HASH_MUL_Y);

	logic [31:0]      xi;
	logic [31:0]      yi;
	logic [31:0]      px_s2;
	logic [31:0]      py_s2;
	logic [31:0]      base;
	logic [3:0][31:0] h_s3;
	logic [3:0][31:0] g_s4;
	logic [3:0][31:0] mix;

	assign xi = 32'($signed(coord_x_s1) >>> FRAC_BITS);
	assign yi = 32'($signed(coord_y_s1) >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			px_s2 <= 32'(xi * HASH_MUL_X);
			py_s2 <= 32'(yi * HASH_MUL_Y);
		end
	end

	assign base = 32'(seed + px_s2 + py_s2);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			h_s3[0] <= base;
			h_s3[1] <= 32'(base + OFS_X);
			h_s3[2] <= 32'(base + OFS_Y);
			h_s3[3] <= 32'(base + OFS_XY);
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mix[k] = h_s3[k] ^ 32'($signed(h_s3[k]) >>> HASH_SHIFT_A);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int k = 0; k < 4; k++) begin
				g_s4[k] <= 32'(mix[k] * HASH_MUL_MIX);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			corner_s4[k] = g_s4[k][15:0] ^ g_s4[k][31:HASH_SHIFT_B];
		end
	end

endmodule
`default_nettype wire

// ----- sv/vnoise_smooth.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vnoise_smooth
	import vnoise_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire stage_en_t   en,
	input  wire logic [31:0] coord_x_s1,
	input  wire logic [31:0] coord_y_s1,
	output logic      [15:0] sx_s3,
	output logic      [15:0] sy_s3
);

	localparam logic [31:0] FRAC_MASK = 32'((64'd1 << FRAC_BITS) - 64'd1);

	logic [31:0] raw_x;
	logic [31:0] raw_y;
	logic [15:0] tx;
	logic [15:0] ty;
	logic [31:0] t2x_s2;
	logic [31:0] t2y_s2;
	logic [17:0] termx_s2;
	logic [17:0] termy_s2;
	logic [49:0] prodx;
	logic [49:0] prody;

	assign raw_x = coord_x_s1 & FRAC_MASK;
	assign raw_y = coord_y_s1 & FRAC_MASK;

	if (FRAC_BITS >= 16) begin : g_trunc
		assign tx = 16'(raw_x >> (FRAC_BITS - 16));
		assign ty = 16'(raw_y >> (FRAC_BITS - 16));
	end else begin : g_extend
		assign tx = 16'(raw_x << (16 - FRAC_BITS));
		assign ty = 16'(raw_y << (16 - FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			t2x_s2   <= 32'(tx * tx);
			t2y_s2   <= 32'(ty * ty);
			termx_s2 <= THREE_Q16 - {1'b0, tx, 1'b0};
			termy_s2 <= THREE_Q16 - {1'b0, ty, 1'b0};
		end
	end

	assign prodx = 50'(t2x_s2) * 50'(termx_s2);
	assign prody = 50'(t2y_s2) * 50'(termy_s2);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sx_s3 <= prodx[47:32];
			sy_s3 <= prody[47:32];
		end
	end

endmodule
`default_nettype wire

// ----- sv/vnoise_lerp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module vnoise_lerp
	import vnoise_pkg::*;
(
	input  wire logic        clk,
	input  wire stage_en_t   en,
	input  wire corner4_t    corner_s4,
	input  wire logic [15:0] sx_s3,
	input  wire logic [15:0] sy_s3,
	output logic      [15:0] noise_s6
);

	// Floor of s*(b-a)/65536 added to a; the arithmetic shift rounds down.
	function automatic logic [15:0] lerp_q16(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] s);
		logic signed [16:0] d;
		logic signed [33:0] p;
		logic        [17:0] r;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		p = $signed({1'b0, s}) * d;
		r = {2'b00, a} + 18'(p[33:16]);
		return r[15:0];
	endfunction

	logic [15:0] sx_s4;
	logic [15:0] sy_s4;
	logic [15:0] sy_s5;
	logic [15:0] nx0_s5;
	logic [15:0] nx1_s5;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			sx_s4 <= sx_s3;
			sy_s4 <= sy_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			nx0_s5 <= lerp_q16(corner_s4[0], corner_s4[1], sx_s4);
			nx1_s5 <= lerp_q16(corner_s4[2], corner_s4[3], sx_s4);
			sy_s5  <= sy_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			noise_s6 <= lerp_q16(nx0_s5, nx1_s5, sy_s5);
		end
	end

endmodule
`default_nettype wire

// ----- sv/value_noise_2d.sv -----
// A request is taken into stage s1 and moves through s2 to s6 to the output register.
// Throughput: one request per cycle unless out_stall holds; six register stages, each with a valid bit.
// A stage takes new data whenever it is empty or its successor moves, so bubbles are squeezed out.
// Reset clears all valid bits and the seed register to zero; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module value_noise_2d
	import vnoise_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [31:0]       coord_x,
	input  wire logic [31:0]       coord_y,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [15:0]       noise_value
);

	logic [31:0] seed;
	logic [31:0] coord_x_s1;
	logic [31:0] coord_y_s1;
	logic [6:1]  vld_q;
	logic [6:1]  adv;
	stage_en_t   en;
	corner4_t    corner_s4;
	logic [15:0] sx_s3;
	logic [15:0] sy_s3;
	logic [15:0] noise_s6;

	always_comb begin
		adv[6] = !vld_q[6] || !out_stall;
		for (int k = 5; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign en.s2 = adv[2];
	assign en.s3 = adv[3];
	assign en.s4 = adv[4];
	assign en.s5 = adv[5];
	assign en.s6 = adv[6];

	assign in_stall = !adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= 6; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			coord_x_s1 <= coord_x;
			coord_y_s1 <= coord_y;
		end
	end

	vnoise_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.seed    (seed)
	);

	vnoise_hash #(
		.FRAC_BITS (FRAC_BITS)
	) u_hash (
		.clk        (clk),
		.en         (en),
		.coord_x_s1 (coord_x_s1),
		.coord_y_s1 (coord_y_s1),
		.seed       (seed),
		.corner_s4  (corner_s4)
	);

	vnoise_smooth #(
		.FRAC_BITS (FRAC_BITS)
	) u_smooth (
		.clk        (clk),
		.en         (en),
		.coord_x_s1 (coord_x_s1),
		.coord_y_s1 (coord_y_s1),
		.sx_s3      (sx_s3),
		.sy_s3      (sy_s3)
	);

	vnoise_lerp u_lerp (
		.clk       (clk),
		.en        (en),
		.corner_s4 (corner_s4),
		.sx_s3     (sx_s3),
		.sy_s3     (sy_s3),
		.noise_s6  (noise_s6)
	);

	assign out_valid   = vld_q[6];
	assign noise_value = noise_s6;

endmodule
`default_nettype wire

// ----- sim/tb_value_noise_2d.sv -----
`timescale 1ns / 1ps
module tb_value_noise_2d;
	import vnoise_pkg::*;

	localparam int FRAC_BITS = 16;
	localparam logic [ADDR_W-1:0] SEED_ADDR = {REG_IDX_SEED, 2'b00};
	localparam int PHASE_POINTS = 213;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] coord_x = '0;
	logic [31:0] coord_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] noise_value;

	point_t points_waiting[$];
	logic [15:0] noise_due[$];
	logic [31:0] seed_now = '0;
	logic req_taken = 1'b0;
	logic send_hold = 1'b0;
	int idle_pct = 9;
	int errors = 0;
	point_t next_point;
	logic [15:0] want;

	value_noise_2d #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.noise_value(noise_value)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] lattice_value(logic [31:0] cx, logic [31:0] cy,
			logic [31:0] seed);
		logic [31:0] h;
		h = seed + cx * HASH_MUL_X + cy * HASH_MUL_Y;
		h = (h ^ 32'($signed(h) >>> HASH_SHIFT_A)) * HASH_MUL_MIX;
		h = h ^ 32'($signed(h) >>> HASH_SHIFT_B);
		return h[15:0];
	endfunction

	function automatic logic [15:0] fade(logic [31:0] raw);
		logic [31:0] t;
		logic [63:0] t2;
		logic [63:0] term;
		logic [63:0] prod;
		t = raw & 32'((64'd1 << FRAC_BITS) - 64'd1);
		if (FRAC_BITS >= 16)
			t = t >> (FRAC_BITS - 16);
		else
			t = t << (16 - FRAC_BITS);
		t = t & 32'hFFFF;
		t2 = 64'(t) * 64'(t);
		term = 64'd196608 - 64'd2 * 64'(t);
		prod = (t2 * term) >> 32;
		return prod[15:0];
	endfunction

	function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, logic [15:0] s);
		logic [63:0] prod;
		if (b >= a) begin
			prod = (64'(s) * 64'(b - a)) >> 16;
			return a + prod[15:0];
		end
		prod = (64'(s) * 64'(a - b) + 64'd65535) >> 16;
		return a - prod[15:0];
	endfunction

	function automatic logic [15:0] noise_at(logic [31:0] rx, logic [31:0] ry,
			logic [31:0] seed);
		logic [31:0] xi;
		logic [31:0] yi;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [15:0] top;
		logic [15:0] bottom;
		xi = 32'($signed(rx) >>> FRAC_BITS);
		yi = 32'($signed(ry) >>> FRAC_BITS);
		sx = fade(rx);
		sy = fade(ry);
		top = blend(lattice_value(xi, yi, seed), lattice_value(xi + 1, yi, seed), sx);
		bottom = blend(lattice_value(xi, yi + 1, seed),
			lattice_value(xi + 1, yi + 1, seed), sx);
		return blend(top, bottom, sy);
	endfunction

	function automatic logic [31:0] random_coord();
		logic [31:0] c;
		case ($urandom_range(0, 4))
			0: c = {16'($urandom_range(0, 7) - 4), 16'($urandom)};
			1: c = {($urandom_range(0, 1) ? 16'h7FFF : 16'h8000), 16'($urandom)};
			2: c = {16'($urandom), ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
			default: c = $urandom;
		endcase
		return c;
	endfunction

	// Driver: holds a request until it is taken, then offers the next one or idles.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !req_taken)) begin
			if (points_waiting.size() != 0 && !send_hold
					&& $urandom_range(0, 99) >= idle_pct) begin
				next_point = points_waiting.pop_front();
				in_valid <= 1'b1;
				coord_x <= next_point.x;
				coord_y <= next_point.y;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(0, 99) < idle_pct);
	end

	// Monitor: predicts on each accepted request and checks each accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken = in_valid && !in_stall;
			if (req_taken)
				noise_due.push_back(noise_at(coord_x, coord_y, seed_now));
			if (out_valid && !out_stall) begin
				if (noise_due.size() == 0) begin
					$error("noise_value: expected none, actual %h", noise_value);
					errors++;
				end else begin
					want = noise_due.pop_front();
					if (noise_value !== want) begin
						$error("noise_value: expected %h, actual %h", want, noise_value);
						errors++;
					end
				end
			end
		end
	end

	task automatic set_seed(input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SEED_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		seed_now = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			$error("noise_seed: expected %h, actual %h", value, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		do @(negedge clk);
		while (points_waiting.size() != 0 || in_valid || noise_due.size() != 0);
	endtask

	task automatic queue_point(input logic [31:0] x, input logic [31:0] y);
		points_waiting.push_back('{x: x, y: y});
	endtask

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++)
			queue_point(random_coord(), random_coord());
	endtask

	initial begin
		logic [31:0] seeds[5];
		seeds = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset seed first: lattice edges, fraction extremes and the cell index wrap.
		queue_point(32'h0000_0000, 32'h0000_0000);
		queue_point(32'h0000_0001, 32'h0000_FFFF);
		queue_point(32'h0000_8000, 32'h0000_8000);
		queue_point(32'h0000_FFFF, 32'h0001_0000);
		queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_point(32'hFFFF_0000, 32'hFFFF_8000);
		queue_point(32'h8000_0000, 32'h8000_0000);
		queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_point(32'h8000_0000, 32'h7FFF_FFFF);
		queue_point(32'h7FFF_0000, 32'h8000_FFFF);
		queue_point(32'hFFFF_FFFF, 32'h0000_0000);
		queue_point(32'h0000_0000, 32'hFFFF_0001);
		queue_point(32'hFFFE_C000, 32'h0003_4000);
		queue_point(32'h1234_5678, 32'hEDCB_A987);
		queue_point(32'hAAAA_AAAA, 32'h5555_5555);
		queue_point(32'h5555_5555, 32'hAAAA_AAAA);
		queue_random(PHASE_POINTS);
		drain();

		for (int p = 0; p < 5; p++) begin
			set_seed(seeds[p]);
			idle_pct = (p == 1) ? 0 : 9;
			queue_random(PHASE_POINTS);
			if (p == 2) begin
				wait (points_waiting.size() < PHASE_POINTS / 2);
				@(negedge clk);
				send_hold <= 1'b1;
				do @(negedge clk); while (in_valid || noise_due.size() != 0);
				send_hold <= 1'b0;
			end
			drain();
		end

		repeat (12) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#3ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
